// ===== src/mrpt_pkg.sv =====
// shared constants and types for the primality tester
`timescale 1ns / 1ps
package mrpt_pkg;
    localparam int NUMBER_WIDTH = 63;
    localparam int BASE_COUNT = 12;
    localparam int BASE_IDX_W = 4;
    localparam int BIT_IDX_W = 6;

    typedef logic [NUMBER_WIDTH-1:0] t_num;

    // witness bases 2..37
    function automatic logic [5:0] f_base(input logic [BASE_IDX_W-1:0] idx);
        logic [5:0] v;
        unique case (idx)
            4'd0: v = 6'd2;
            4'd1: v = 6'd3;
            4'd2: v = 6'd5;
            4'd3: v = 6'd7;
            4'd4: v = 6'd11;
            4'd5: v = 6'd13;
            4'd6: v = 6'd17;
            4'd7: v = 6'd19;
            4'd8: v = 6'd23;
            4'd9: v = 6'd29;
            4'd10: v = 6'd31;
            4'd11: v = 6'd37;
            default: v = 6'd2;
        endcase
        return v;
    endfunction

    // modular add, x < m and y < m
    function automatic t_num f_add_mod(input t_num x, input t_num y, input t_num m);
        logic [NUMBER_WIDTH:0] s;
        logic [NUMBER_WIDTH:0] t;
        s = {1'b0, x} + {1'b0, y};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[NUMBER_WIDTH-1:0] : s[NUMBER_WIDTH-1:0];
    endfunction

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctl;
endpackage

// ===== src/mrpt_mulmod.sv =====
// shift-and-add modular multiplier, one bit of b per cycle
`timescale 1ns / 1ps
module mrpt_mulmod import mrpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_num     i_a,
    input  t_num     i_b,
    input  t_num     i_m,
    output t_mul_ctl o_ctl,
    output t_num     o_p
);
    logic r_busy, n_busy;
    logic r_done, n_done;
    t_num r_acc, n_acc;
    t_num r_add, n_add;
    t_num r_b, n_b;

    // operands arrive already reduced below m
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_acc = r_acc;
        n_add = r_add;
        n_b = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_acc = '0;
            n_add = i_a;
            n_b = i_b;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_b[0]) n_acc = f_add_mod(r_acc, r_add, i_m);
                n_add = f_add_mod(r_add, r_add, i_m);
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_add <= n_add;
        r_b <= n_b;
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_p = r_acc;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_acc_below_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < i_m)) else $error("product not reduced");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start not taken");
`endif
endmodule

// ===== src/miller_rabin_primality_test.sv =====
// top level: deterministic miller-rabin test over twelve fixed bases
// usage:
//   input channel i_valid / o_stall with i_candidate (63 bits)
//   output channel o_valid / i_stall with o_is_prime
//   a transaction is taken when valid is high and stall is low
// multiplier: each modular multiply steps serially through the bits of its second
//   operand, on a single shared multiplier
//   a full prime near 2^63 needs up to about 12 * 125 multiplies; trivial
//   inputs (below 3 or even) are decided in the split step without any
//   multiply
// throughput: one candidate at a time; o_stall is high from acceptance
//   until the result transaction completes
// reset: synchronous active-low i_rst_n returns the sequencer to idle
//   and drops o_valid; no clearing pass is needed
// receiver stall: the result is held in an output register with o_valid
//   high until i_stall goes low; no new candidate is taken meanwhile
`timescale 1ns / 1ps
module miller_rabin_primality_test import mrpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_candidate,
    output logic o_valid,
    input  logic i_stall,
    output logic o_is_prime
);
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SPLIT  = 9'b000000010,
        ST_BASE   = 9'b000000100,
        ST_EXP    = 9'b000001000,
        ST_WAIT   = 9'b000010000,
        ST_CHECK  = 9'b000100000,
        ST_SQR    = 9'b001000000,
        ST_OUT    = 9'b010000000,
        ST_REDUCE = 9'b100000000
    } t_state;

    // what the running multiply feeds
    typedef enum logic [1:0] {
        OP_RESULT  = 2'd0,
        OP_SQUARE  = 2'd1,
        OP_WITNESS = 2'd2
    } t_mul_op;

    t_state r_state, n_state;
    t_num r_n, n_n;
    t_num r_d, n_d;
    t_num r_e, n_e;
    t_num r_x, n_x;
    t_num r_sq, n_sq;
    logic [BIT_IDX_W-1:0] r_s, n_s;
    logic [BIT_IDX_W-1:0] r_r, n_r;
    logic [BASE_IDX_W-1:0] r_bi, n_bi;
    logic r_res, n_res;
    t_mul_op r_op, n_op;

    logic mul_start;
    t_num mul_a, mul_b, mul_p;
    t_mul_ctl mul_ctl;
    t_num nm1;
    t_num base_v;

    assign nm1 = r_n - t_num'(1);
    assign base_v = t_num'(f_base(r_bi));

    mrpt_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .i_m(r_n), .o_ctl(mul_ctl), .o_p(mul_p)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_n = r_n; n_d = r_d; n_e = r_e; n_x = r_x; n_sq = r_sq;
        n_s = r_s; n_r = r_r; n_bi = r_bi; n_res = r_res;
        n_op = r_op;
        mul_start = 1'b0;
        mul_a = r_x;
        mul_b = r_sq;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_n = i_candidate;
                    n_state = ST_SPLIT;
                    n_d = i_candidate - t_num'(1);
                    n_s = '0;
                    n_bi = '0;
                end
            end
            ST_SPLIT: begin
                if (r_n < t_num'(2)) begin
                    n_res = 1'b0; n_state = ST_OUT;
                end else if (r_n == t_num'(2)) begin
                    n_res = 1'b1; n_state = ST_OUT;
                end else if (!r_n[0]) begin
                    n_res = 1'b0; n_state = ST_OUT;
                end else if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + 1'b1;
                end else begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                if (r_bi == BASE_IDX_W'(BASE_COUNT)) begin
                    n_res = 1'b1; n_state = ST_OUT;
                end else if (base_v == r_n) begin
                    // odd n > 2 below 64 divides a base only by equality
                    n_bi = r_bi + 1'b1;
                end else begin
                    n_x = t_num'(1);
                    n_sq = base_v;
                    n_e = r_d;
                    n_state = ST_REDUCE;
                end
            end
            // base mod n by repeated subtraction, only n below the base need any subtraction
            ST_REDUCE: begin
                if (r_sq >= r_n) begin
                    n_sq = r_sq - r_n;
                end else begin
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                if (r_e == '0) begin
                    n_r = BIT_IDX_W'(1);
                    n_state = ST_CHECK;
                end else if (r_e[0]) begin
                    mul_start = 1'b1;
                    mul_a = r_x; mul_b = r_sq;
                    n_op = OP_RESULT;
                    n_state = ST_WAIT;
                end else begin
                    mul_start = 1'b1;
                    mul_a = r_sq; mul_b = r_sq;
                    n_op = OP_SQUARE;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mul_ctl.done) begin
                    unique case (r_op)
                        OP_RESULT: begin
                            n_x = mul_p;
                            mul_start = 1'b1;
                            mul_a = r_sq; mul_b = r_sq;
                            n_op = OP_SQUARE;
                        end
                        OP_SQUARE: begin
                            n_sq = mul_p;
                            n_e = r_e >> 1;
                            n_state = ST_EXP;
                        end
                        default: begin
                            n_x = mul_p;
                            n_r = r_r + 1'b1;
                            n_state = ST_SQR;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (r_x == t_num'(1) || r_x == nm1) begin
                    n_bi = r_bi + 1'b1; n_state = ST_BASE;
                end else if (r_r >= r_s) begin
                    n_res = 1'b0; n_state = ST_OUT;
                end else begin
                    mul_start = 1'b1;
                    mul_a = r_x; mul_b = r_x;
                    n_op = OP_WITNESS;
                    n_state = ST_WAIT;
                end
            end
            ST_SQR: begin
                if (r_x == nm1) begin
                    n_bi = r_bi + 1'b1; n_state = ST_BASE;
                end else if (r_r >= r_s) begin
                    n_res = 1'b0; n_state = ST_OUT;
                end else begin
                    mul_start = 1'b1;
                    mul_a = r_x; mul_b = r_x;
                    n_op = OP_WITNESS;
                    n_state = ST_WAIT;
                end
            end
            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n <= n_n; r_d <= n_d; r_e <= n_e; r_x <= n_x; r_sq <= n_sq;
        r_s <= n_s; r_r <= n_r; r_bi <= n_bi; r_res <= n_res;
        r_op <= n_op;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_is_prime = r_res;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_is_prime)))
        else $error("result dropped under stall");
    a_mul_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_ctl.done |-> (r_state == ST_WAIT)) else $error("stray product");
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_x < r_n)) else $error("x not reduced");
`endif
endmodule
